// ===== src/edtt_pkg.sv =====
// Shared types and constants of the earliest-deadline timer table.
// Used by the channel interfaces, the timer cell and the top level.
package edtt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int NOW_W         = 48;
    localparam int DL_W          = 49;
    localparam int WORD_W        = 32;
    localparam int SLOT_FIELD_W  = 4;
    localparam int REQ_W         = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_QUERY = 2'd3
    } req_e;

    // Contents of one armed timer slot.
    typedef struct packed {
        logic [DL_W-1:0]   deadline;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] arg;
    } entry_t;

    // Update broadcast from the control to every cell.
    typedef struct packed {
        logic                    add;
        logic                    del;
        logic [SLOT_FIELD_W-1:0] slot;
        entry_t                  entry;
    } cell_cmd_t;

endpackage

// ===== src/edtt_if.sv =====
// Request and response channel interfaces of the timer table.
// Depends on edtt_pkg for the field widths.
interface edtt_in_if;
    logic                              valid;
    logic                              ready;
    logic [edtt_pkg::REQ_W-1:0]        req_type;
    logic [edtt_pkg::SLOT_FIELD_W-1:0] slot;
    logic [edtt_pkg::WORD_W-1:0]       delay_ms;
    logic [edtt_pkg::WORD_W-1:0]       callback_tag;
    logic [edtt_pkg::WORD_W-1:0]       callback_arg;

    modport source (output valid, output req_type, output slot, output delay_ms,
                    output callback_tag, output callback_arg, input ready);
    modport sink   (input valid, input req_type, input slot, input delay_ms,
                    input callback_tag, input callback_arg, output ready);
endinterface

interface edtt_out_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [edtt_pkg::SLOT_FIELD_W-1:0] earliest_slot;
    logic [edtt_pkg::WORD_W-1:0]       remaining_ms;
    logic [edtt_pkg::WORD_W-1:0]       tag_out;
    logic [edtt_pkg::WORD_W-1:0]       arg_out;

    modport source (output valid, output found, output earliest_slot, output remaining_ms,
                    output tag_out, output arg_out, input ready);
    modport sink   (input valid, input found, input earliest_slot, input remaining_ms,
                    input tag_out, input arg_out, output ready);
endinterface

// ===== src/edtt_cell.sv =====
// One timer slot of the table plus one stage of the earliest-deadline chain.
// Depends on edtt_pkg for the entry and command types.
module edtt_cell #(
    parameter int NUM_SLOTS = edtt_pkg::NUM_SLOTS_DEF,
    parameter int IDX       = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  edtt_pkg::cell_cmd_t            cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0]   new_pos,
    input  logic [$clog2(NUM_SLOTS)-1:0]   gone_pos,
    output logic                           armed,
    output logic [$clog2(NUM_SLOTS)-1:0]   pos,
    input  logic                           cand_have_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]   cand_slot_in,
    input  logic [$clog2(NUM_SLOTS)-1:0]   cand_pos_in,
    input  edtt_pkg::entry_t               cand_entry_in,
    output logic                           cand_have_out,
    output logic [$clog2(NUM_SLOTS)-1:0]   cand_slot_out,
    output logic [$clog2(NUM_SLOTS)-1:0]   cand_pos_out,
    output edtt_pkg::entry_t               cand_entry_out
);
    import edtt_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] OWN_SLOT = SLOT_W'(IDX);

    logic              armed_reg, armed_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    entry_t            entry_reg, entry_next;
    logic              cand_have_reg, cand_have_next;
    logic [SLOT_W-1:0] cand_slot_reg, cand_slot_next;
    logic [SLOT_W-1:0] cand_pos_reg, cand_pos_next;
    entry_t            cand_entry_reg, cand_entry_next;
    logic              hit;
    logic              win;

    assign hit = (32'(cmd.slot) == IDX);

    always_comb
    begin
        armed_next = armed_reg;
        pos_next   = pos_reg;
        entry_next = entry_reg;
        if (cmd.add && hit)
        begin
            // A slot that is already armed keeps its place in the order.
            if (!armed_reg)
            begin
                armed_next = 1'b1;
                pos_next   = new_pos;
            end
            entry_next = cmd.entry;
        end
        else if (cmd.del)
        begin
            if (hit)
                armed_next = 1'b0;
            else if (armed_reg && (pos_reg > gone_pos))
                pos_next = pos_reg - SLOT_W'(1);
        end
    end

    // Ties on the deadline go to the slot that was armed later.
    always_comb
    begin
        win = armed_reg &&
              (!cand_have_in ||
               (entry_reg.deadline < cand_entry_in.deadline) ||
               ((entry_reg.deadline == cand_entry_in.deadline) && (pos_reg > cand_pos_in)));
        cand_have_next  = cand_have_in || armed_reg;
        cand_slot_next  = win ? OWN_SLOT  : cand_slot_in;
        cand_pos_next   = win ? pos_reg   : cand_pos_in;
        cand_entry_next = win ? entry_reg : cand_entry_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            cand_have_reg <= 1'b0;
        end
        else
        begin
            armed_reg     <= armed_next;
            cand_have_reg <= cand_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        entry_reg      <= entry_next;
        cand_slot_reg  <= cand_slot_next;
        cand_pos_reg   <= cand_pos_next;
        cand_entry_reg <= cand_entry_next;
    end

    assign armed          = armed_reg;
    assign pos            = pos_reg;
    assign cand_have_out  = cand_have_reg;
    assign cand_slot_out  = cand_slot_reg;
    assign cand_pos_out   = cand_pos_reg;
    assign cand_entry_out = cand_entry_reg;

endmodule

// ===== src/earliest_deadline_timer_table.sv =====
// Earliest-deadline timer table: NUM_SLOTS cells in a row, searched by a candidate chain.
// Tick, add, delete: the finishing state registers the result once the output is free.
// Query: the candidate passes one cell per cycle; the scan state runs the full chain,
// then the remainder state and the finishing state; a new beat is taken only back in idle.
// Reset clears the millisecond counter, the armed bits and the armed count; slot contents
// are left as they are and are only read for armed slots.
module earliest_deadline_timer_table #(
    parameter int NUM_SLOTS = edtt_pkg::NUM_SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    edtt_in_if.sink    req,
    edtt_out_if.source rsp
);
    import edtt_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int EXT_W  = SLOT_W + SLOT_FIELD_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_REM  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       cnt_reg, cnt_next;
    logic [NOW_W-1:0]        now_reg, now_next;
    logic [SLOT_W:0]         count_reg, count_next;

    logic                    pend_found_reg, pend_found_next;
    logic [SLOT_FIELD_W-1:0] pend_slot_reg, pend_slot_next;
    logic [WORD_W-1:0]       pend_rem_reg, pend_rem_next;
    logic [WORD_W-1:0]       pend_tag_reg, pend_tag_next;
    logic [WORD_W-1:0]       pend_arg_reg, pend_arg_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic [WORD_W-1:0]       out_rem_reg, out_rem_next;
    logic [WORD_W-1:0]       out_tag_reg, out_tag_next;
    logic [WORD_W-1:0]       out_arg_reg, out_arg_next;

    cell_cmd_t               cmd;
    logic [NUM_SLOTS-1:0]    armed_vec;
    logic [SLOT_W-1:0]       pos_vec [NUM_SLOTS];
    logic                    cand_have  [NUM_SLOTS+1];
    logic [SLOT_W-1:0]       cand_slot  [NUM_SLOTS+1];
    logic [SLOT_W-1:0]       cand_pos   [NUM_SLOTS+1];
    entry_t                  cand_entry [NUM_SLOTS+1];

    logic                    accept;
    logic                    slot_ok;
    logic                    tgt_armed;
    logic [SLOT_W-1:0]       gone_pos;
    logic [DL_W-1:0]         dl_sum;
    logic [DL_W-1:0]         diff;
    logic [WORD_W-1:0]       rem;
    logic [EXT_W-1:0]        slot_ext;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_ok   = (32'(req.slot) < NUM_SLOTS);
    assign dl_sum    = DL_W'(now_reg) + DL_W'(req.delay_ms);

    // Armed bit and order position of the addressed slot.
    always_comb
    begin
        tgt_armed = 1'b0;
        gone_pos  = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (32'(req.slot) == i)
            begin
                tgt_armed = armed_vec[i];
                gone_pos  = pos_vec[i];
            end
        end
    end

    always_comb
    begin
        cmd.add         = accept && (req_e'(req.req_type) == REQ_ADD) && slot_ok;
        cmd.del         = accept && (req_e'(req.req_type) == REQ_DEL) && slot_ok && tgt_armed;
        cmd.slot        = req.slot;
        cmd.entry.deadline = dl_sum;
        cmd.entry.tag   = req.callback_tag;
        cmd.entry.arg   = req.callback_arg;
    end

    assign cand_have[0]  = 1'b0;
    assign cand_slot[0]  = '0;
    assign cand_pos[0]   = '0;
    assign cand_entry[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        edtt_cell #(
            .NUM_SLOTS (NUM_SLOTS),
            .IDX       (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .new_pos        (count_reg[SLOT_W-1:0]),
            .gone_pos       (gone_pos),
            .armed          (armed_vec[g]),
            .pos            (pos_vec[g]),
            .cand_have_in   (cand_have[g]),
            .cand_slot_in   (cand_slot[g]),
            .cand_pos_in    (cand_pos[g]),
            .cand_entry_in  (cand_entry[g]),
            .cand_have_out  (cand_have[g+1]),
            .cand_slot_out  (cand_slot[g+1]),
            .cand_pos_out   (cand_pos[g+1]),
            .cand_entry_out (cand_entry[g+1])
        );
    end

    // Remaining time of the winner, clamped at zero and saturated to 32 bits.
    always_comb
    begin
        diff     = cand_entry[NUM_SLOTS].deadline - DL_W'(now_reg);
        slot_ext = EXT_W'(cand_slot[NUM_SLOTS]);
        if (cand_entry[NUM_SLOTS].deadline <= DL_W'(now_reg))
            rem = '0;
        else if (diff[DL_W-1:WORD_W] != '0)
            rem = '1;
        else
            rem = diff[WORD_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        pend_found_next = pend_found_reg;
        pend_slot_next  = pend_slot_reg;
        pend_rem_next   = pend_rem_reg;
        pend_tag_next   = pend_tag_reg;
        pend_arg_next   = pend_arg_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_slot_next   = out_slot_reg;
        out_rem_next    = out_rem_reg;
        out_tag_next    = out_tag_reg;
        out_arg_next    = out_arg_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_found_next = 1'b0;
                    pend_slot_next  = '0;
                    pend_rem_next   = '0;
                    pend_tag_next   = '0;
                    pend_arg_next   = '0;
                    state_next      = ST_FIN;
                    unique case (req_e'(req.req_type))
                        REQ_TICK:
                        begin
                            if (now_reg != '1)
                                now_next = now_reg + NOW_W'(1);
                        end
                        REQ_ADD:
                        begin
                            if (cmd.add && !tgt_armed)
                                count_next = count_reg + (SLOT_W+1)'(1);
                        end
                        REQ_DEL:
                        begin
                            if (cmd.del)
                                count_next = count_reg - (SLOT_W+1)'(1);
                        end
                        REQ_QUERY:
                        begin
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // The last cell holds the winner once the chain has run its full length.
                if (cnt_reg == SLOT_W'(NUM_SLOTS - 1))
                    state_next = ST_REM;
                else
                    cnt_next = cnt_reg + SLOT_W'(1);
            end
            ST_REM:
            begin
                if (cand_have[NUM_SLOTS])
                begin
                    pend_found_next = 1'b1;
                    pend_slot_next  = slot_ext[SLOT_FIELD_W-1:0];
                    pend_rem_next   = rem;
                    pend_tag_next   = cand_entry[NUM_SLOTS].tag;
                    pend_arg_next   = cand_entry[NUM_SLOTS].arg;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_slot_next  = pend_slot_reg;
                    out_rem_next   = pend_rem_reg;
                    out_tag_next   = pend_tag_reg;
                    out_arg_next   = pend_arg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            now_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_found_reg <= pend_found_next;
        pend_slot_reg  <= pend_slot_next;
        pend_rem_reg   <= pend_rem_next;
        pend_tag_reg   <= pend_tag_next;
        pend_arg_reg   <= pend_arg_next;
        out_found_reg  <= out_found_next;
        out_slot_reg   <= out_slot_next;
        out_rem_reg    <= out_rem_next;
        out_tag_reg    <= out_tag_next;
        out_arg_reg    <= out_arg_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.earliest_slot = out_slot_reg;
    assign rsp.remaining_ms  = out_rem_reg;
    assign rsp.tag_out       = out_tag_reg;
    assign rsp.arg_out       = out_arg_reg;

    // The armed count must always match the armed bits spread over the cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(armed_vec) == int'(count_reg))
        else $error("armed count differs from armed cells");

    // A new result beat only appears out of the finishing state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the finishing state");

    // The millisecond counter never runs backward.
    a_now_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> now_reg >= $past(now_reg))
        else $error("millisecond counter decreased");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for earliest_deadline_timer_table: directed and random requests,
// with every response checked against a prediction of the slot table kept in the bench.
// Depends on edtt_pkg, the edtt_in_if / edtt_out_if interfaces and the top level in src.
module tb_top;
    import edtt_pkg::*;

    localparam int                SLOTS     = NUM_SLOTS_DEF;
    localparam logic [NOW_W-1:0]  NOW_LIMIT = '1;
    localparam logic [WORD_W-1:0] WORD_MAX  = '1;

    typedef struct packed {
        logic                    found;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [WORD_W-1:0]       remaining;
        logic [WORD_W-1:0]       tag;
        logic [WORD_W-1:0]       arg;
    } timer_rsp_t;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   mismatches;
    int   requests_sent;
    int   responses_seen;
    int   queries_hit;
    int   queries_empty;

    edtt_in_if  req_if();
    edtt_out_if rsp_if();

    earliest_deadline_timer_table #(
        .NUM_SLOTS(SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Predicted contents of the timer table.
    logic [NOW_W-1:0]  now_ms;
    logic              slot_armed    [SLOTS];
    logic [DL_W-1:0]   slot_deadline [SLOTS];
    logic [WORD_W-1:0] slot_tag      [SLOTS];
    logic [WORD_W-1:0] slot_arg      [SLOTS];
    int unsigned       slot_order    [SLOTS];
    int unsigned       armed_total;
    timer_rsp_t        pending_rsp[$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void clear_table();
        now_ms      = '0;
        armed_total = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_armed[i]    = 1'b0;
            slot_deadline[i] = '0;
            slot_tag[i]      = '0;
            slot_arg[i]      = '0;
            slot_order[i]    = 0;
        end
    endfunction

    // Applies one request to the predicted table and returns the response it causes.
    function automatic timer_rsp_t predict_response(req_e kind, logic [SLOT_FIELD_W-1:0] slot,
                                                    logic [WORD_W-1:0] delay,
                                                    logic [WORD_W-1:0] tag,
                                                    logic [WORD_W-1:0] arg);
        timer_rsp_t      r;
        int              s;
        int              best;
        int unsigned     gone;
        logic [DL_W-1:0] gap;
        r = '0;
        s = int'(slot);
        case (kind)
            REQ_TICK:
            begin
                if (now_ms != NOW_LIMIT)
                    now_ms = now_ms + NOW_W'(1);
            end
            REQ_ADD:
            begin
                if (s < SLOTS)
                begin
                    // A slot that is already armed keeps its place in the order.
                    if (!slot_armed[s])
                    begin
                        slot_armed[s] = 1'b1;
                        slot_order[s] = armed_total;
                        armed_total++;
                    end
                    slot_deadline[s] = {1'b0, now_ms} + DL_W'(delay);
                    slot_tag[s]      = tag;
                    slot_arg[s]      = arg;
                end
            end
            REQ_DEL:
            begin
                if (s < SLOTS && slot_armed[s])
                begin
                    gone          = slot_order[s];
                    slot_armed[s] = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_armed[i] && slot_order[i] > gone)
                            slot_order[i]--;
                    if (armed_total > 0)
                        armed_total--;
                end
            end
            default:
            begin
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_armed[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                        (slot_deadline[i] == slot_deadline[best] &&
                         slot_order[i] > slot_order[best])))
                        best = i;
                end
                if (best >= 0)
                begin
                    gap = (slot_deadline[best] > {1'b0, now_ms}) ?
                          slot_deadline[best] - {1'b0, now_ms} : '0;
                    r.found     = 1'b1;
                    r.slot      = best[SLOT_FIELD_W-1:0];
                    r.remaining = (gap > DL_W'(WORD_MAX)) ? WORD_MAX : gap[WORD_W-1:0];
                    r.tag       = slot_tag[best];
                    r.arg       = slot_arg[best];
                end
            end
        endcase
        return r;
    endfunction

    // Presents one request beat and records the response it must produce.
    task automatic send_req(req_e kind, logic [SLOT_FIELD_W-1:0] slot, logic [WORD_W-1:0] delay,
                            logic [WORD_W-1:0] tag, logic [WORD_W-1:0] arg);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 19);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.slot         <= slot;
        req_if.delay_ms     <= delay;
        req_if.callback_tag <= tag;
        req_if.callback_arg <= arg;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        pending_rsp.push_back(predict_response(kind, slot, delay, tag, arg));
        requests_sent++;
        if (kind == REQ_QUERY)
        begin
            if (pending_rsp[$].found)
                queries_hit++;
            else
                queries_empty++;
        end
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Response side: random stall bursts while idling is on, always ready otherwise.
    initial
    begin : rsp_ready_gen
        int run;
        bit stall;
        run  = 0;
        stall = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!idle_on)
                rsp_if.ready <= 1'b1;
            else
            begin
                if (run == 0)
                begin
                    stall = ($urandom_range(0, 99) < 35);
                    run   = $urandom_range(1, 19);
                end
                rsp_if.ready <= !stall;
                run--;
            end
        end
    end

    initial
    begin : rsp_checker
        timer_rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                responses_seen++;
                if (pending_rsp.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("found", WORD_W'(want.found), WORD_W'(rsp_if.found));
                    check_field("earliest_slot", WORD_W'(want.slot),
                                WORD_W'(rsp_if.earliest_slot));
                    check_field("remaining_ms", want.remaining, rsp_if.remaining_ms);
                    check_field("tag_out", want.tag, rsp_if.tag_out);
                    check_field("arg_out", want.arg, rsp_if.arg_out);
                end
            end
        end
    end

    task automatic test_empty_table();
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
        send_req(REQ_DEL, 4'd4, '0, '0, '0);
        send_req(REQ_TICK, 4'd0, '0, '0, '0);
        send_req(REQ_QUERY, 4'd9, 32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9);
    endtask

    task automatic test_field_limits();
        send_req(REQ_ADD, 4'd0, '0, '0, '0);
        send_req(REQ_ADD, 4'd15, WORD_MAX, WORD_MAX, WORD_MAX);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
        send_req(REQ_DEL, 4'd0, '0, '0, '0);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
        send_req(REQ_DEL, 4'd15, WORD_MAX, WORD_MAX, WORD_MAX);
        send_req(REQ_QUERY, 4'd15, '0, '0, '0);
    endtask

    // Equal deadlines go to the slot latest in insertion order; a rearm keeps its place.
    task automatic test_order_ties();
        send_req(REQ_ADD, 4'd3, 32'd20, 32'h0000_0a03, 32'h0000_0b03);
        send_req(REQ_ADD, 4'd7, 32'd20, 32'h0000_0a07, 32'h0000_0b07);
        send_req(REQ_ADD, 4'd5, 32'd20, 32'h0000_0a05, 32'h0000_0b05);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
        send_req(REQ_ADD, 4'd3, 32'd20, 32'h5555_aaaa, 32'haaaa_5555);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
        send_req(REQ_DEL, 4'd5, '0, '0, '0);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
    endtask

    task automatic test_expired_deadline();
        send_req(REQ_ADD, 4'd9, 32'd2, 32'hdead_0009, 32'hbeef_0009);
        repeat (3) send_req(REQ_TICK, 4'd0, '0, '0, '0);
        send_req(REQ_QUERY, 4'd0, '0, '0, '0);
    endtask

    // Random traffic; the weights steer the table toward full or toward empty.
    task automatic test_random_traffic(int count, int tick_pct, int add_pct, int del_pct);
        int                      pick;
        int                      armed_list[$];
        req_e                    kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [WORD_W-1:0]       delay;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)
                kind = REQ_TICK;
            else if (pick < tick_pct + add_pct)
                kind = REQ_ADD;
            else if (pick < tick_pct + add_pct + del_pct)
                kind = REQ_DEL;
            else
                kind = REQ_QUERY;
            slot = SLOT_FIELD_W'($urandom_range(0, 15));
            if (kind == REQ_DEL && $urandom_range(0, 99) < 75)
            begin
                armed_list.delete();
                for (int i = 0; i < SLOTS; i++)
                    if (slot_armed[i])
                        armed_list.push_back(i);
                if (armed_list.size() > 0)
                    slot = SLOT_FIELD_W'(armed_list[$urandom_range(0, armed_list.size() - 1)]);
            end
            // Coarse delays make equal deadlines common; a few span the whole field.
            case ($urandom_range(0, 9))
                0:       delay = $urandom();
                1, 2, 3: delay = 8 * $urandom_range(0, 4);
                default: delay = $urandom_range(0, 60);
            endcase
            send_req(kind, slot, delay, $urandom(), $urandom());
        end
    endtask

    initial
    begin : stimulus
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_TICK;
        req_if.slot         = '0;
        req_if.delay_ms     = '0;
        req_if.callback_tag = '0;
        req_if.callback_arg = '0;
        clear_table();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_field_limits();
        test_order_ties();
        test_expired_deadline();
        test_random_traffic(350, 30, 35, 10);
        test_random_traffic(250, 20, 10, 40);
        idle_on = 1'b0;
        test_random_traffic(300, 25, 30, 20);

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("summary: %0d requests sent, %0d responses checked", requests_sent,
                 responses_seen);
        $display("summary: %0d queries found a slot, %0d saw an empty table, now at %0d ms",
                 queries_hit, queries_empty, now_ms);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
